[rtl/blr_pkg.sv]
package blr_pkg;

    localparam int PIX_W     = 32;
    localparam int COORD_W   = 11;
    localparam int CFG_DIM_W = 12;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hff00_0000;

    // Lane sums: 16 * 255 and 9 * 255 both fit in 12 bits.
    localparam int LANE_W  = 8;
    localparam int LANES   = 3;
    localparam int SUM_W   = 12;
    localparam int PROD_W  = 24;
    // floor(s / 9) == (s * 3641) >> 15 for every s below 2304
    localparam logic [SUM_W-1:0] BOX_RECIP = 12'd3641;
    localparam int BOX_SHIFT = 15;

    // Result queue
    localparam int Q_DEPTH = 16;
    localparam int Q_AW    = 4;
    localparam int Q_CW    = 5;
    localparam int MAX_RES = 4;
    localparam int RES_CW  = 3;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BLUR_KIND    = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        BLUR_GAUSS = 1'b0,
        BLUR_BOX   = 1'b1
    } blur_kind_t;

    // Which results one input pixel causes, in emission order
    typedef struct packed {
        logic near_main;   // (r-1, c-1)
        logic near_edge;   // (r-1, W-1)
        logic last_main;   // (H-1, c-1)
        logic last_edge;   // (H-1, W-1), end of frame
        logic interior;    // (r-1, c-1) gets the filter
        logic parity;      // row parity of the input pixel
    } emit_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               frame_end;
    } res_t;

endpackage

[rtl/blr_ifs.sv]
interface blr_in_if;
    import blr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface blr_out_if;
    import blr_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_end;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input frame_end, output ready);
endinterface

[rtl/blur_3x3_stream.sv]
// Streaming 3x3 blur over 32-bit pixels in raster order. Each interior pixel
// leaves with alpha forced to 0xff and every colour byte replaced by either the
// 1-2-1 Gaussian sum over 16 (blur_kind 0) or the 3x3 box mean (blur_kind 1);
// the first and last row and column pass through unchanged. Results carry
// their row, column and an end-of-frame flag on the last pixel. The block
// takes one pixel per clock while the output side takes one result per clock;
// each result passes the window, sum and result stages, then the result queue. The
// end of each row adds one extra result and the last row gives two results per
// pixel, so there the single output port sets the rate. A 16-entry result
// queue absorbs these bursts; the input stalls only when fewer than four queue
// slots remain unclaimed. The two line buffers need no clearing after reset.
// Writing any register restarts the frame; write registers only while the
// block is idle. Widths and heights outside 3..MAX are clamped.
module blur_3x3_stream #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    blr_in_if.sink                       pix_in,
    blr_out_if.source                    pix_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [blr_pkg::APB_AW-1:0]   paddr,
    input  logic [blr_pkg::APB_DW-1:0]   pwdata,
    output logic [blr_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import blr_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DIM_W-1:0] frame_width_reg;
    logic [CFG_DIM_W-1:0] frame_height_reg;
    blur_kind_t           blur_kind_reg;
    cfg_reg_t             cfg_sel;
    logic                 cfg_wr;
    logic                 cfg_hit;

    assign cfg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_sel)
            REG_FRAME_WIDTH,
            REG_FRAME_HEIGHT,
            REG_BLUR_KIND:    cfg_hit = 1'b1;
            default:          cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_DIM_W'(640);
            frame_height_reg <= CFG_DIM_W'(480);
            blur_kind_reg    <= BLUR_GAUSS;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_BLUR_KIND:    blur_kind_reg    <= blur_kind_t'(pwdata[0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_reg);
            REG_BLUR_KIND:    prdata = APB_DW'(blur_kind_reg);
            default:          prdata = '0;
        endcase
    end

    // Clamped last column and last row
    logic [WW-1:0] w_last;
    logic [RW-1:0] h_last;

    always_comb
    begin
        if (int'(frame_width_reg) < 3)
            w_last = WW'(2);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            w_last = WW'(MAX_WIDTH - 1);
        else
            w_last = WW'(frame_width_reg - CFG_DIM_W'(1));

        if (int'(frame_height_reg) < 3)
            h_last = RW'(2);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(frame_height_reg - CFG_DIM_W'(1));
    end

    // ------------------------------------------------------------------
    // Stage 0: accept, position counters, line buffer access
    // ------------------------------------------------------------------
    logic [Q_CW-1:0] reserved_reg;
    logic [Q_CW-1:0] reserved_next;
    logic [RW-1:0]   row_cnt_reg;
    logic [RW-1:0]   row_cnt_next;
    logic [WW-1:0]   col_cnt_reg;
    logic [WW-1:0]   col_cnt_next;
    logic            in_xfer;
    logic            out_xfer;
    emit_t           emit0;
    logic [RES_CW-1:0] n_res0;

    // Ready only while at least four queue slots are unclaimed by pixels in flight
    assign pix_in.ready = (reserved_reg <= Q_CW'(Q_DEPTH - MAX_RES));
    assign in_xfer      = pix_in.valid && pix_in.ready;
    assign out_xfer     = pix_out.valid && pix_out.ready;

    always_comb
    begin
        emit0.near_main = (col_cnt_reg != '0) && (row_cnt_reg != '0);
        emit0.near_edge = emit0.near_main && (col_cnt_reg == w_last);
        emit0.last_main = (col_cnt_reg != '0) && (row_cnt_reg == h_last);
        emit0.last_edge = emit0.last_main && (col_cnt_reg == w_last);
        emit0.interior  = (row_cnt_reg > RW'(1)) && (col_cnt_reg > WW'(1));
        emit0.parity    = row_cnt_reg[0];

        n_res0 = RES_CW'(emit0.near_main) + RES_CW'(emit0.near_edge)
               + RES_CW'(emit0.last_main) + RES_CW'(emit0.last_edge);

        // Claim queue slots at accept, release them as results transfer out
        reserved_next = reserved_reg;
        if (in_xfer)
            reserved_next = reserved_next + Q_CW'(n_res0);
        if (out_xfer)
            reserved_next = reserved_next - Q_CW'(1);

        // Advance raster position; wrap to next row and next frame
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        if (cfg_wr && cfg_hit)
        begin
            row_cnt_next = '0;
            col_cnt_next = '0;
        end
        else if (in_xfer)
        begin
            if (col_cnt_reg == w_last)
            begin
                col_cnt_next = '0;
                if (row_cnt_reg == h_last)
                    row_cnt_next = '0;
                else
                    row_cnt_next = row_cnt_reg + RW'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + WW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
        end
    end

    // Two line buffers selected by row parity. The buffer of the current
    // parity holds row r-2 and is overwritten with row r; read returns the
    // old word.
    logic [PIX_W-1:0] line0_mem [MAX_WIDTH];
    logic [PIX_W-1:0] line1_mem [MAX_WIDTH];
    logic [PIX_W-1:0] line0_rd_reg;
    logic [PIX_W-1:0] line1_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            line0_rd_reg <= line0_mem[col_cnt_reg];
            if (!row_cnt_reg[0])
                line0_mem[col_cnt_reg] <= pix_in.pixel_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            line1_rd_reg <= line1_mem[col_cnt_reg];
            if (row_cnt_reg[0])
                line1_mem[col_cnt_reg] <= pix_in.pixel_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: shift the 3x3 window and load the new column
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    emit_t            s1_emit_reg;
    logic [RW-1:0]    s1_row_reg;
    logic [WW-1:0]    s1_col_reg;
    logic [PIX_W-1:0] s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_emit_reg <= emit0;
            s1_row_reg  <= row_cnt_reg;
            s1_col_reg  <= col_cnt_reg;
            s1_pix_reg  <= pix_in.pixel_in;
        end
    end

    // win_reg: rows r-2, r-1, r by columns c-2, c-1, c
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] up2_word;
    logic [PIX_W-1:0] up1_word;

    assign up2_word = s1_emit_reg.parity ? line1_rd_reg : line0_rd_reg;
    assign up1_word = s1_emit_reg.parity ? line0_rd_reg : line1_rd_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= up2_word;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= up1_word;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-lane weighted and plain sums over the window
    // ------------------------------------------------------------------
    logic             s2_valid_reg;
    emit_t            s2_emit_reg;
    logic [RW-1:0]    s2_row_reg;
    logic [WW-1:0]    s2_col_reg;
    logic [SUM_W-1:0] gauss_sum [LANES];
    logic [SUM_W-1:0] box_sum   [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_emit_reg <= s1_emit_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            gauss_sum[k] = (SUM_W'(win_reg[4][LANE_W*k +: LANE_W]) << 2)
                         + ((SUM_W'(win_reg[1][LANE_W*k +: LANE_W])
                           + SUM_W'(win_reg[3][LANE_W*k +: LANE_W])
                           + SUM_W'(win_reg[5][LANE_W*k +: LANE_W])
                           + SUM_W'(win_reg[7][LANE_W*k +: LANE_W])) << 1)
                         + SUM_W'(win_reg[0][LANE_W*k +: LANE_W])
                         + SUM_W'(win_reg[2][LANE_W*k +: LANE_W])
                         + SUM_W'(win_reg[6][LANE_W*k +: LANE_W])
                         + SUM_W'(win_reg[8][LANE_W*k +: LANE_W]);
            box_sum[k] = '0;
            for (int i = 0; i < 9; i++)
                box_sum[k] = box_sum[k] + SUM_W'(win_reg[i][LANE_W*k +: LANE_W]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: finish the lanes, build results, write them to the queue
    // ------------------------------------------------------------------
    logic             s3_valid_reg;
    emit_t            s3_emit_reg;
    logic [RW-1:0]    s3_row_reg;
    logic [WW-1:0]    s3_col_reg;
    logic [SUM_W-1:0] s3_gauss_reg [LANES];
    logic [SUM_W-1:0] s3_box_reg   [LANES];
    logic [PIX_W-1:0] s3_ctr_reg;      // window centre (r-1, c-1)
    logic [PIX_W-1:0] s3_up_right_reg; // (r-1, c)
    logic [PIX_W-1:0] s3_left_reg;     // (r, c-1)
    logic [PIX_W-1:0] s3_right_reg;    // (r, c)

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_emit_reg     <= s2_emit_reg;
            s3_row_reg      <= s2_row_reg;
            s3_col_reg      <= s2_col_reg;
            s3_ctr_reg      <= win_reg[4];
            s3_up_right_reg <= win_reg[5];
            s3_left_reg     <= win_reg[7];
            s3_right_reg    <= win_reg[8];
            for (int k = 0; k < LANES; k++)
            begin
                s3_gauss_reg[k] <= gauss_sum[k];
                s3_box_reg[k]   <= box_sum[k];
            end
        end
    end

    logic [PROD_W-1:0]  box_prod [LANES];
    logic [PIX_W-1:0]   filt_word;
    logic [RW-1:0]      row_m1;
    logic [WW-1:0]      col_m1;
    res_t               res   [MAX_RES];
    logic               res_en [MAX_RES];
    logic [1:0]         res_pos [MAX_RES];
    logic [RES_CW-1:0]  n_res3;

    assign row_m1 = s3_row_reg - RW'(1);
    assign col_m1 = s3_col_reg - WW'(1);

    always_comb
    begin
        filt_word = ALPHA_OPAQUE;
        for (int k = 0; k < LANES; k++)
        begin
            box_prod[k] = PROD_W'(s3_box_reg[k]) * PROD_W'(BOX_RECIP);
            if (blur_kind_reg == BLUR_BOX)
                filt_word[LANE_W*k +: LANE_W] = box_prod[k][BOX_SHIFT +: LANE_W];
            else
                filt_word[LANE_W*k +: LANE_W] = s3_gauss_reg[k][SUM_W-1 -: LANE_W];
        end

        res[0].pixel_out = s3_emit_reg.interior ? filt_word : s3_ctr_reg;
        res[0].out_row   = COORD_W'(row_m1);
        res[0].out_col   = COORD_W'(col_m1);
        res[0].frame_end = 1'b0;

        res[1].pixel_out = s3_up_right_reg;
        res[1].out_row   = COORD_W'(row_m1);
        res[1].out_col   = COORD_W'(w_last);
        res[1].frame_end = 1'b0;

        res[2].pixel_out = s3_left_reg;
        res[2].out_row   = COORD_W'(s3_row_reg);
        res[2].out_col   = COORD_W'(col_m1);
        res[2].frame_end = 1'b0;

        res[3].pixel_out = s3_right_reg;
        res[3].out_row   = COORD_W'(s3_row_reg);
        res[3].out_col   = COORD_W'(w_last);
        res[3].frame_end = 1'b1;

        res_en[0] = s3_valid_reg && s3_emit_reg.near_main;
        res_en[1] = s3_valid_reg && s3_emit_reg.near_edge;
        res_en[2] = s3_valid_reg && s3_emit_reg.last_main;
        res_en[3] = s3_valid_reg && s3_emit_reg.last_edge;

        // Pack enabled results into consecutive queue slots
        res_pos[0] = 2'd0;
        res_pos[1] = 2'd1;
        res_pos[2] = {1'b0, s3_emit_reg.near_main} + {1'b0, s3_emit_reg.near_edge};
        res_pos[3] = res_pos[2] + 2'd1;

        n_res3 = RES_CW'(res_en[0]) + RES_CW'(res_en[1])
               + RES_CW'(res_en[2]) + RES_CW'(res_en[3]);
    end

    // ------------------------------------------------------------------
    // Result queue: up to four writes, one read per cycle
    // ------------------------------------------------------------------
    res_t            q_data_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] q_count_reg;
    logic [Q_CW-1:0] q_count_next;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_RES; j++)
        begin
            if (res_en[j])
                q_data_reg[wr_ptr_reg + Q_AW'(res_pos[j])] <= res[j];
        end
    end

    always_comb
    begin
        q_count_next = q_count_reg + Q_CW'(n_res3);
        if (out_xfer)
            q_count_next = q_count_next - Q_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_reg + Q_AW'(n_res3);
            q_count_reg <= q_count_next;
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
        end
    end

    // Present the queue head
    assign pix_out.valid     = (q_count_reg != '0);
    assign pix_out.pixel_out = q_data_reg[rd_ptr_reg].pixel_out;
    assign pix_out.out_row   = q_data_reg[rd_ptr_reg].out_row;
    assign pix_out.out_col   = q_data_reg[rd_ptr_reg].out_col;
    assign pix_out.frame_end = q_data_reg[rd_ptr_reg].frame_end;

endmodule
